>>> design/adam_optimizer_update_unit_macros.svh
// assertion helpers for the update unit rtl
`ifndef ADAM_OPTIMIZER_UPDATE_UNIT_MACROS_SVH
`define ADAM_OPTIMIZER_UPDATE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ADAM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ADAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/adam_pkg.sv
`timescale 1ns / 1ps
package adam_pkg;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  // divider operand sizes
  localparam int unsigned DIV_NUM_W = 96;
  localparam int unsigned DIV_DEN_W = 33;
  localparam int unsigned DIV_Q_W   = 64;
  localparam int unsigned DIV_CNT_W = 7;

  // configuration register indexes
  localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] CFG_BETA_FIRST    = 2'd1;
  localparam logic [1:0] CFG_BETA_SECOND   = 2'd2;
  localparam logic [1:0] CFG_EPSILON_TERM  = 2'd3;

  localparam logic [23:0] LR_RESET  = 24'd16777;
  localparam logic [31:0] B1_RESET  = 32'd3865470566;
  localparam logic [31:0] B2_RESET  = 32'd4290672329;
  localparam logic [23:0] EPS_RESET = 24'd1;

  // 1.0 in unsigned q1.32
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

endpackage

>>> design/adam_optimizer_update_unit.sv
`timescale 1ns / 1ps
// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+--------------------------------------
// item      | in        | start && !busy              | element_index_i, param_value_i,
//           |           |                             | gradient_i, first_of_step_i
// result    | out       | result_valid_o (1 cycle)    | new_param_o, out_index_o, saturated_o
// config    | in        | cfg_valid_i && cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one item at a time; a transaction runs the multiply steps, the first-moment divide launch and wait,
// the second-moment divide launch and wait, the square root, the step setup and the step divide
// wait, in that order; a bias correction and its divide are skipped while its beta power is still
// exactly one; the result strobe comes in the first idle cycle
// the single shared divider and the one 33x33 multiplier serve all of these steps
// after reset a clearing pass writes zero to all 4096 moment entries, with busy held high
// the receiver cannot stall; each result is shown for exactly one cycle
module adam_optimizer_update_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [adam_pkg::IDX_W-1:0] element_index_i,
  input  logic signed [31:0]         param_value_i,
  input  logic signed [31:0]         gradient_i,
  input  logic                       first_of_step_i,
  output logic                       result_valid_o,
  output logic signed [31:0]         new_param_o,
  output logic [adam_pkg::IDX_W-1:0] out_index_o,
  output logic                       saturated_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [31:0]                cfg_data_i
);
  import adam_pkg::*;

`include "adam_optimizer_update_unit_macros.svh"

  // sequencer codes
  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_POW1   = 5'd2;
  localparam logic [4:0] S_POW2   = 5'd3;
  localparam logic [4:0] S_MOM    = 5'd4;
  localparam logic [4:0] S_VH     = 5'd5;
  localparam logic [4:0] S_VL     = 5'd6;
  localparam logic [4:0] S_G2     = 5'd7;
  localparam logic [4:0] S_G2H    = 5'd8;
  localparam logic [4:0] S_G2L    = 5'd9;
  localparam logic [4:0] S_VSUM   = 5'd10;
  localparam logic [4:0] S_DIVM   = 5'd11;
  localparam logic [4:0] S_DIVM_W = 5'd12;
  localparam logic [4:0] S_DIVV   = 5'd13;
  localparam logic [4:0] S_DIVV_W = 5'd14;
  localparam logic [4:0] S_SQRT   = 5'd15;
  localparam logic [4:0] S_LR     = 5'd16;
  localparam logic [4:0] S_STEP   = 5'd17;
  localparam logic [4:0] S_FIN_W  = 5'd18;

  logic [4:0] state_q, state_d;

  // configuration registers
  logic [23:0] lr_q;
  logic [31:0] b1_q;
  logic [31:0] b2_q;
  logic [23:0] eps_q;

  // running beta powers, q1.32
  logic [32:0] p1_q;
  logic [32:0] p2_q;

  // moment stores
  logic [31:0] m_mem [DEPTH];
  logic [63:0] v_mem [DEPTH];
  logic [31:0] m_rd_q;
  logic [63:0] v_rd_q;
  logic        mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic [31:0] mem_wm;
  logic [63:0] mem_wv;
  logic [IDX_W-1:0] clr_cnt_q;

  // latched item
  logic [IDX_W-1:0]   idx_q;
  logic signed [31:0] param_q;
  logic signed [31:0] grad_q;
  logic               first_q;

  // datapath
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_q;
  logic signed [31:0] m_new_q;
  logic [63:0] acc_q;
  logic [63:0] g2_q;
  logic [63:0] t_q;
  logic [63:0] v_new_q;
  logic [63:0] v_new;
  logic [31:0] mh_q;
  logic [63:0] rem_q;
  logic [63:0] root_q;
  logic [63:0] bit_q;
  logic [4:0]  sq_cnt_q;
  logic [32:0] denom_q;
  logic [32:0] denom_sum;
  logic [63:0] sq_trial;

  logic [32:0] c1;
  logic [32:0] c2;
  logic [32:0] cb2;
  logic [31:0] gmag;
  logic [31:0] mmag;
  logic        mneg;
  logic        accept;

  // divider hookup
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_dividend;
  logic [DIV_CNT_W-1:0] div_count;
  logic [DIV_DEN_W-1:0] div_divisor;
  logic                 div_done;
  logic [DIV_Q_W-1:0]   div_quot;

  // final combine
  logic signed [57:0] res;
  logic               res_sat;
  logic               result_valid_q;
  logic signed [31:0] new_param_q;
  logic [IDX_W-1:0]   out_index_q;
  logic               saturated_q;

  // clamp a corrected first-moment magnitude to the signed 32-bit range
  function automatic logic [31:0] clamp_mh(input logic [63:0] q, input logic neg);
    if (neg) begin
      clamp_mh = (q > 64'h8000_0000) ? 32'h8000_0000 : q[31:0];
    end else begin
      clamp_mh = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
  endfunction

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign c1   = ONE_Q32 - p1_q;
  assign c2   = ONE_Q32 - p2_q;
  assign cb2  = ONE_Q32 - {1'b0, b2_q};
  assign gmag = grad_q[31] ? (32'd0 - grad_q) : grad_q;
  assign mneg = m_new_q[31];
  assign mmag = mneg ? (32'd0 - m_new_q) : m_new_q;

  // v = b2*v + (1-b2)*g^2, with the b2 == 0 case taking g^2 whole
  assign v_new = acc_q + ((b2_q == 32'd0) ? g2_q : (t_q + {32'd0, prod_q[63:32]}));

  assign sq_trial  = root_q + bit_q;
  assign denom_sum = {1'b0, root_q[31:0]} + {9'd0, eps_q};

  // configuration writes, taken any time (only legal while idle)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LR_RESET;
      b1_q  <= B1_RESET;
      b2_q  <= B2_RESET;
      eps_q <= EPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_LEARNING_RATE: lr_q  <= cfg_data_i[23:0];
        CFG_BETA_FIRST:    b1_q  <= cfg_data_i;
        CFG_BETA_SECOND:   b2_q  <= cfg_data_i;
        CFG_EPSILON_TERM:  eps_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_POW1: begin
        mul_a = {1'b0, b1_q};
        mul_b = {1'b0, p1_q[31:0]};
      end
      S_POW2: begin
        mul_a = {1'b0, b2_q};
        mul_b = {1'b0, p2_q[31:0]};
      end
      S_MOM: begin
        // m' = g + floor((m - g) * b1 / 2^32)
        mul_a = {m_rd_q[31], m_rd_q} - {grad_q[31], grad_q};
        mul_b = {1'b0, b1_q};
      end
      S_VH: begin
        mul_a = {1'b0, v_rd_q[63:32]};
        mul_b = {1'b0, b2_q};
      end
      S_VL: begin
        mul_a = {1'b0, v_rd_q[31:0]};
        mul_b = {1'b0, b2_q};
      end
      S_G2: begin
        mul_a = {1'b0, gmag};
        mul_b = {1'b0, gmag};
      end
      S_G2H: begin
        mul_a = {1'b0, prod_q[63:32]};
        mul_b = {1'b0, cb2[31:0]};
      end
      S_G2L: begin
        mul_a = {1'b0, g2_q[31:0]};
        mul_b = {1'b0, cb2[31:0]};
      end
      S_LR: begin
        mul_a = {9'd0, lr_q};
        mul_b = {1'b0, mh_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_count    = '0;
    div_divisor  = '0;
    case (state_q)
      S_DIVM: begin
        div_start    = !p1_q[32];
        div_dividend = {32'd0, mmag, 32'd0};
        div_count    = DIV_CNT_W'(DIV_NUM_W);
        div_divisor  = c1;
      end
      S_DIVV: begin
        div_start    = !p2_q[32];
        div_dividend = {v_new_q, 32'd0};
        div_count    = DIV_CNT_W'(DIV_NUM_W);
        div_divisor  = c2;
      end
      S_STEP: begin
        // lr * |m_hat| fits 56 bits, left aligned
        div_start    = 1'b1;
        div_dividend = {prod_q[55:0], 40'd0};
        div_count    = DIV_CNT_W'(56);
        div_divisor  = denom_q;
      end
      default: ;
    endcase
  end

  adam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .count_i    (div_count),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // memory ports: one write (clear pass or write-back), one registered read
  always_comb begin
    mem_we   = (state_q == S_CLR) || (state_q == S_VSUM);
    mem_addr = (state_q == S_CLR) ? clr_cnt_q : idx_q;
    mem_wm   = (state_q == S_CLR) ? 32'd0 : m_new_q;
    mem_wv   = (state_q == S_CLR) ? 64'd0 : v_new;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      m_mem[mem_addr] <= mem_wm;
      v_mem[mem_addr] <= mem_wv;
    end
    if (accept) begin
      m_rd_q <= m_mem[element_index_i];
      v_rd_q <= v_mem[element_index_i];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:    if (clr_cnt_q == IDX_W'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:   if (start) state_d = S_POW1;
      S_POW1:   state_d = S_POW2;
      S_POW2:   state_d = S_MOM;
      S_MOM:    state_d = S_VH;
      S_VH:     state_d = S_VL;
      S_VL:     state_d = S_G2;
      S_G2:     state_d = S_G2H;
      S_G2H:    state_d = S_G2L;
      S_G2L:    state_d = S_VSUM;
      S_VSUM:   state_d = S_DIVM;
      S_DIVM:   state_d = p1_q[32] ? S_DIVV : S_DIVM_W;
      S_DIVM_W: if (div_done) state_d = S_DIVV;
      S_DIVV:   state_d = p2_q[32] ? S_SQRT : S_DIVV_W;
      S_DIVV_W: if (div_done) state_d = S_SQRT;
      S_SQRT:   if (sq_cnt_q == 5'd31) state_d = S_LR;
      S_LR:     state_d = S_STEP;
      S_STEP:   state_d = S_FIN_W;
      S_FIN_W:  if (div_done) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      clr_cnt_q      <= '0;
      p1_q           <= ONE_Q32;
      p2_q           <= ONE_Q32;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= (state_q == S_FIN_W) && div_done;
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
      // beta powers advance before the moments are used
      if (state_q == S_POW2 && first_q) begin
        p1_q <= p1_q[32] ? {1'b0, b1_q} : {1'b0, prod_q[63:32]};
      end
      if (state_q == S_MOM && first_q) begin
        p2_q <= p2_q[32] ? {1'b0, b2_q} : {1'b0, prod_q[63:32]};
      end
    end
  end

  // final add and saturation
  always_comb begin
    if (mneg) begin
      res = 58'(param_q) + $signed({2'b00, div_quot[55:0]});
    end else begin
      res = 58'(param_q) - $signed({2'b00, div_quot[55:0]});
    end
    res_sat = (res > 58'sd2147483647) || (res < -58'sd2147483648);
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q   <= element_index_i;
      param_q <= param_value_i;
      grad_q  <= gradient_i;
      first_q <= first_of_step_i;
    end
    case (state_q)
      S_VH:   m_new_q <= grad_q + prod_q[63:32];
      S_VL:   acc_q <= prod_q[63:0];
      S_G2:   acc_q <= acc_q + {32'd0, prod_q[63:32]};
      S_G2H:  g2_q <= prod_q[63:0];
      S_G2L:  t_q <= prod_q[63:0];
      S_VSUM: v_new_q <= v_new;
      S_DIVM: if (p1_q[32]) mh_q <= clamp_mh({32'd0, mmag}, mneg);
      S_DIVM_W: if (div_done) mh_q <= clamp_mh(div_quot, mneg);
      S_DIVV: begin
        rem_q    <= v_new_q;
        root_q   <= '0;
        bit_q    <= 64'h4000_0000_0000_0000;
        sq_cnt_q <= '0;
      end
      S_DIVV_W: if (div_done) rem_q <= div_quot;
      S_SQRT: begin
        // one result bit per cycle
        if (rem_q >= sq_trial) begin
          rem_q  <= rem_q - sq_trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q    <= bit_q >> 2;
        sq_cnt_q <= sq_cnt_q + 5'd1;
      end
      S_LR: denom_q <= (denom_sum == 33'd0) ? 33'd1 : denom_sum;
      S_FIN_W: if (div_done) begin
        new_param_q <= res_sat ? (res[57] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : res[31:0];
        saturated_q <= res_sat;
        out_index_q <= idx_q;
      end
      default: ;
    endcase
  end

  assign result_valid_o = result_valid_q;
  assign new_param_o    = new_param_q;
  assign out_index_o    = out_index_q;
  assign saturated_o    = saturated_q;

  `ADAM_ASSERT_IMPL(a_result_after_final, result_valid_o, $past(state_q == S_FIN_W), "result strobe without a finished step")
  `ADAM_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `ADAM_ASSERT_IMPL(a_no_write_idle, mem_we, state_q != S_IDLE, "moment store written while idle")
  `ADAM_ASSERT_IMPL(a_div_done_waited, div_done, state_q == S_DIVM_W || state_q == S_DIVV_W || state_q == S_FIN_W, "divider finished outside a wait state")

endmodule

>>> design/adam_div.sv
`timescale 1ns / 1ps
module adam_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [adam_pkg::DIV_NUM_W-1:0]     dividend_i,
  input  logic [adam_pkg::DIV_CNT_W-1:0]     count_i,
  input  logic [adam_pkg::DIV_DEN_W-1:0]     divisor_i,
  output logic                               done_o,
  output logic [adam_pkg::DIV_Q_W-1:0]       quot_o
);
  import adam_pkg::*;

  // restoring divider, one quotient bit per cycle, msb of dividend first
  logic                 busy_q;
  logic                 done_q;
  logic                 ovf_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] sh_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] divisor_q;
  logic [DIV_Q_W-1:0]   quot_q;

  logic [DIV_DEN_W:0]   r_sh;
  logic                 ge;
  logic [DIV_DEN_W:0]   r_sub;

  assign r_sh  = {rem_q, sh_q[DIV_NUM_W-1]};
  assign ge    = r_sh >= {1'b0, divisor_q};
  assign r_sub = r_sh - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= count_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q      <= dividend_i;
      rem_q     <= '0;
      quot_q    <= '0;
      ovf_q     <= 1'b0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      sh_q   <= {sh_q[DIV_NUM_W-2:0], 1'b0};
      ovf_q  <= ovf_q | quot_q[DIV_Q_W-1];
      quot_q <= {quot_q[DIV_Q_W-2:0], ge};
      rem_q  <= ge ? r_sub[DIV_DEN_W-1:0] : r_sh[DIV_DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = ovf_q ? '1 : quot_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import adam_pkg::*;

  typedef struct packed {
    logic signed [31:0] new_param;
    logic [IDX_W-1:0]   index;
    logic               sat;
  } update_t;

  // watchdog: cycles without any transaction; covers the clearing pass and a slow item
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned DRAIN_CYCLES = 400;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [IDX_W-1:0]         element_index_i = '0;
  logic signed [31:0]       param_value_i = '0;
  logic signed [31:0]       gradient_i = '0;
  logic                     first_of_step_i = 1'b0;
  logic                     result_valid_o;
  logic signed [31:0]       new_param_o;
  logic [IDX_W-1:0]         out_index_o;
  logic                     saturated_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_index_i = '0;
  logic [31:0]              cfg_data_i = '0;

  adam_optimizer_update_unit dut (
    .clk_i, .rst_ni, .start, .busy, .element_index_i, .param_value_i, .gradient_i,
    .first_of_step_i, .result_valid_o, .new_param_o, .out_index_o, .saturated_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // shadow copy of the engine: registers, moment stores and running beta powers
  logic [23:0]        lr_q;
  logic [31:0]        b1_q, b2_q;
  logic [23:0]        eps_q;
  logic signed [31:0] m_store [DEPTH];
  logic [63:0]        v_store [DEPTH];
  logic [32:0]        b1_pow, b2_pow;

  update_t     pending_updates[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          idle_enable = 1'b1;
  // indexes that get revisited so the moments build up over many steps
  logic [IDX_W-1:0] hot_index [16];

  // floor(a * b / 2^32)
  function automatic logic [63:0] scale_q32(input logic [63:0] a, input logic [32:0] b);
    logic [127:0] p;
    p = a * b;
    return p[95:32];
  endfunction

  // floor(a * 2^32 / d), clipped to 64 bits
  function automatic logic [63:0] unbias_q32(input logic [63:0] a, input logic [32:0] d);
    logic [127:0] q;
    q = {a, 32'd0};
    q = q / d;
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] rem, root, b;
    rem = x;
    root = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // one parameter update; advances shadow state and returns the expected result
  function automatic update_t adam_update(input logic [IDX_W-1:0] idx,
                                          input logic signed [31:0] param,
                                          input logic signed [31:0] grad,
                                          input logic first);
    logic signed [127:0] ms, gs, b1s, acc;
    logic signed [31:0]  m;
    logic [63:0]         gmag, g2, v, mmag, mh, vh, denom, step;
    logic [32:0]         c1, c2;
    logic signed [63:0]  res;
    logic                neg;
    update_t             r;
    if (first) begin
      b1_pow = 33'(scale_q32(64'(b1_q), b1_pow));
      b2_pow = 33'(scale_q32(64'(b2_q), b2_pow));
    end
    ms = m_store[idx];
    gs = grad;
    b1s = {96'd0, b1_q};
    acc = ms * b1s + gs * (128'sd4294967296 - b1s);
    m = 32'(acc >>> 32);
    m_store[idx] = m;
    gmag = (grad < 0) ? 64'(-64'(grad)) : 64'(grad);
    g2 = gmag * gmag;
    v = scale_q32(v_store[idx], {1'b0, b2_q}) + scale_q32(g2, ONE_Q32 - {1'b0, b2_q});
    v_store[idx] = v;
    c1 = ONE_Q32 - b1_pow;
    c2 = ONE_Q32 - b2_pow;
    neg = m < 0;
    mmag = neg ? 64'(-64'(m)) : 64'(m);
    // no correction while the power is still exactly one
    mh = (c1 == 0) ? mmag : unbias_q32(mmag, c1);
    if (neg && mh > 64'h8000_0000) mh = 64'h8000_0000;
    if (!neg && mh > 64'h7FFF_FFFF) mh = 64'h7FFF_FFFF;
    vh = (c2 == 0) ? v : unbias_q32(v, c2);
    denom = floor_sqrt(vh) + 64'(eps_q);
    if (denom == 0) denom = 1;  // zero root and zero epsilon
    step = (64'(lr_q) * mh) / denom;
    res = neg ? 64'(param) + $signed(step) : 64'(param) - $signed(step);
    r.sat = 1'b0;
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      r.sat = 1'b1;
    end
    if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.new_param = 32'(res);
    r.index = idx;
    return r;
  endfunction

  // any accepted transaction resets the stall counter
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** adam_optimizer_update_unit: FAILED **");
        $finish;
      end
    end
  end

  // result checker: every strobe must match the oldest pending update
  always @(posedge clk_i) begin
    update_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_updates.size() == 0) begin
        $error("unexpected result transaction, new_param %h index %0d", new_param_o,
               out_index_o);
        error_count++;
      end else begin
        e = pending_updates.pop_front();
        if (new_param_o !== e.new_param) begin
          $error("new_param expected %h actual %h", e.new_param, new_param_o);
          error_count++;
        end
        if (out_index_o !== e.index) begin
          $error("out_index expected %0d actual %0d", e.index, out_index_o);
          error_count++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated expected %b actual %b", e.sat, saturated_o);
          error_count++;
        end
      end
    end
  end

  // drive one item; while idle_enable is set, start is withheld at random in any cycle until it is taken
  task automatic send_item(input logic [IDX_W-1:0] idx, input logic signed [31:0] param,
                           input logic signed [31:0] grad, input logic first);
    bit go;
    element_index_i <= idx;
    param_value_i <= param;
    gradient_i <= grad;
    first_of_step_i <= first;
    do begin
      go = !idle_enable || ($urandom_range(99) >= 18);
      start <= go;
      @(posedge clk_i);
    end while (!go || busy);
    pending_updates.push_back(adam_update(idx, param, grad, first));
  endtask

  // let the engine go idle before touching the registers
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    if (idle_enable && $urandom_range(99) < 18) repeat ($urandom_range(1, 4)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LEARNING_RATE: lr_q = data[23:0];
      CFG_BETA_FIRST:    b1_q = data;
      CFG_BETA_SECOND:   b2_q = data;
      CFG_EPSILON_TERM:  eps_q = data[23:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [23:0] lr, input logic [31:0] b1,
                          input logic [31:0] b2, input logic [23:0] eps);
    wait_idle();
    write_reg(CFG_LEARNING_RATE, {8'($urandom), lr});  // upper bits are don't-care
    write_reg(CFG_BETA_FIRST, b1);
    write_reg(CFG_BETA_SECOND, b2);
    write_reg(CFG_EPSILON_TERM, {8'($urandom), eps});
  endtask

  // gradients in several magnitude bands, full range now and then
  function automatic logic signed [31:0] rand_grad();
    case ($urandom_range(3))
      0: return $signed(32'($urandom_range(0, 2 ** 20))) - 32'sd524288;
      1: return $signed(32'($urandom_range(0, 2 ** 26))) - 32'sd33554432;
      2: return '0 | $signed(32'($urandom));
      default: return $signed(32'($urandom_range(0, 2 ** 12))) - 32'sd2048;
    endcase
  endfunction

  // reset values, very first items: uncorrected moments then the first step
  task automatic test_first_steps();
    send_item('0, 32'sd16777216, 32'sd1677721, 1'b0);
    send_item(12'd1, -32'sd16777216, -32'sd1677721, 1'b0);
    send_item('0, 32'sd16777216, 32'sd1677721, 1'b1);
    send_item(12'd1, -32'sd16777216, -32'sd1677721, 1'b0);
    send_item('1, 32'sd0, 32'sd0, 1'b0);
  endtask

  // field extremes and saturation in both directions
  task automatic test_field_extremes();
    send_item('1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_item('1, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_item(12'd2, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_item(12'd3, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_item(12'hAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0);
    send_item(12'h555, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b1);
  endtask

  // register extremes: max step, zero and max decays, zero epsilon
  task automatic test_register_extremes();
    set_regs(24'hFF_FFFF, 32'd0, 32'd0, 24'd0);
    send_item(12'd4, 32'sd0, 32'sh0100_0000, 1'b1);
    send_item(12'd5, 32'sd0, 32'sd0, 1'b0);     // zero root and zero epsilon
    send_item(12'd6, 32'sh7FFF_0000, -32'sd1, 1'b0);
    set_regs(24'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
    send_item(12'd7, 32'sd12345, 32'sh7FFF_FFFF, 1'b1);
    send_item(12'd7, 32'sd12345, -32'sd7, 1'b1);
    set_regs(24'hFF_FFFF, 32'hFFFF_FFFF, 32'd1, 24'd0);
    send_item(12'd8, 32'sd0, -32'sd3, 1'b1);   // negative moment floors to -1 lsb
    send_item(12'd8, 32'sd0, 32'sd0, 1'b0);
    send_item(12'd9, 32'sh8000_0000, -32'sd1000000, 1'b1);
  endtask

  // mostly well-formed training steps over a hot set, plus scattered indexes
  task automatic test_random_steps(input int unsigned count, input logic [23:0] lr,
                                   input logic [31:0] b1, input logic [31:0] b2,
                                   input logic [23:0] eps);
    logic [IDX_W-1:0] idx;
    set_regs(lr, b1, b2, eps);
    for (int unsigned n = 0; n < count; n++) begin
      idx = ($urandom_range(99) < 75) ? hot_index[n % 16] : IDX_W'($urandom);
      send_item(idx, $signed(32'($urandom)) >>> $urandom_range(0, 8), rand_grad(),
                (n % 16 == 0) || ($urandom_range(99) < 3));
    end
  endtask

  initial begin
    lr_q = LR_RESET;
    b1_q = B1_RESET;
    b2_q = B2_RESET;
    eps_q = EPS_RESET;
    b1_pow = ONE_Q32;
    b2_pow = ONE_Q32;
    for (int i = 0; i < DEPTH; i++) begin
      m_store[i] = '0;
      v_store[i] = '0;
    end
    for (int i = 0; i < 16; i++) hot_index[i] = IDX_W'($urandom);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_first_steps();
    test_field_extremes();
    test_register_extremes();
    test_random_steps(330, LR_RESET, B1_RESET, B2_RESET, EPS_RESET);
    idle_enable = 1'b0;  // back-to-back stretch
    test_random_steps(330, 24'($urandom), 32'hF000_0000 | $urandom, $urandom, 24'($urandom));
    idle_enable = 1'b1;
    test_random_steps(330, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0);
    test_random_steps(330, 24'd1, 32'd0, 32'd0, 24'hFF_FFFF);
    test_random_steps(310, 24'($urandom), $urandom, 32'hFFF0_0000 | $urandom, 24'($urandom));

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** adam_optimizer_update_unit: PASSED **");
    end else begin
      $display("** adam_optimizer_update_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/adam_pkg.sv
design/adam_div.sv
design/adam_optimizer_update_unit.sv
tb/testbench.sv
